/* rtl/ypid_pkg.sv */
`default_nettype none
package ypid_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned ERR_W  = DATA_W + 1;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned FRAC_SHIFT = 15;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] S16_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] S16_MIN = 16'sh8000;

  localparam logic signed [DATA_W-1:0] GAIN_P_RESET = 16'sd12800;
  localparam logic signed [DATA_W-1:0] GAIN_I_RESET = 16'sd256;

  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_TARGET       = 3'd3,
    REG_BASE_A       = 3'd4,
    REG_BASE_B       = 3'd5,
    REG_BASE_C       = 3'd6,
    REG_BASE_D       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] p;
    logic signed [DATA_W-1:0] i;
    logic signed [DATA_W-1:0] d;
  } gains_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
  } bases_t;

  // error terms of one sample
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] esum;
    logic signed [ERR_W:0]   delta;
  } err_word_t;

  function automatic logic signed [DATA_W-1:0] sat17(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? S16_MIN : S16_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/yaw_pid_four_motor_mixer.sv */
// yaw hold pid controller with four motor differential mixer
// in_*  : one yaw sample word per handshake (signed q8.7 degrees)
// out_* : one result word per sample, in order: four motor drives and the
//         saturated correction (motors a/b get base minus correction,
//         c/d get base plus correction)
// cfg_* : register writes (gains p/i/d q8.8, setpoint, four base speeds),
//         taken at any edge with cfg_wr_en high; write only while idle
// latency: 3 cycles from the input accept edge to out_tvalid; four register
// stages (error and integral, multiply, sum/shift/saturate, mixer), the
// first one loaded at the accept edge
// throughput: one sample per cycle; the integral and last-error update is
// a single-cycle loop at the input stage, the three products run in parallel
// each stage has its own valid and fills bubbles, so input keeps flowing
// while the output word waits until the pipeline is full
// a stalled receiver holds out_tdata steady; once all four stages hold
// words, in_tready drops
// reset (rst_n low, synchronous) empties the pipeline, clears the integral
// and last error, and loads the register defaults (kp 50.0, ki 1.0)
`default_nettype none
module yaw_pid_four_motor_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] heading_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] drive_a, [31:16] drive_b, [47:32] drive_c, [63:48] drive_d,
  // [79:64] correction
  output logic [79:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import ypid_pkg::*;

  gains_t                   gains_r;
  bases_t                   bases_r;
  logic signed [DATA_W-1:0] target_r;
  logic                     s1_valid;
  logic                     s1_ready;
  err_word_t                s1_word;
  logic                     corr_valid;
  logic                     corr_ready;
  logic signed [DATA_W-1:0] corr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.p <= GAIN_P_RESET;
      gains_r.i <= GAIN_I_RESET;
      gains_r.d <= '0;
      target_r  <= '0;
      bases_r   <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_addr))
        REG_GAIN_P: gains_r.p <= cfg_wdata;
        REG_GAIN_I: gains_r.i <= cfg_wdata;
        REG_GAIN_D: gains_r.d <= cfg_wdata;
        REG_TARGET: target_r  <= cfg_wdata;
        REG_BASE_A: bases_r.a <= cfg_wdata;
        REG_BASE_B: bases_r.b <= cfg_wdata;
        REG_BASE_C: bases_r.c <= cfg_wdata;
        REG_BASE_D: bases_r.d <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ypid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sample   (in_tdata),
    .target   (target_r),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s1_ready (s1_ready)
  );

  ypid_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .gains      (gains_r),
    .s1_valid   (s1_valid),
    .s1_word    (s1_word),
    .s1_ready   (s1_ready),
    .corr_valid (corr_valid),
    .corr       (corr),
    .corr_ready (corr_ready)
  );

  ypid_mixer u_mixer (
    .clk        (clk),
    .rst_n      (rst_n),
    .bases      (bases_r),
    .corr_valid (corr_valid),
    .corr       (corr),
    .corr_ready (corr_ready),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .out_ready  (out_tready)
  );

endmodule
`default_nettype wire

/* rtl/ypid_front.sv */
`default_nettype none
module ypid_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        sample,
  input  logic signed [15:0]        target,
  output logic                      s1_valid,
  output ypid_pkg::err_word_t       s1_word,
  input  logic                      s1_ready
);
  import ypid_pkg::*;

  logic                     accept;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    esum_wide;
  logic signed [SUM_W-1:0]  esum_nxt;
  logic signed [SUM_W-1:0]  esum_r;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W:0]    delta;
  logic                     s1_v_r;
  logic                     s1_v_nxt;
  err_word_t                s1_r;

  assign in_ready = !s1_v_r || s1_ready;
  assign accept   = in_valid && in_ready;

  assign err       = {target[DATA_W-1], target} - {sample[DATA_W-1], sample};
  assign esum_wide = {esum_r[SUM_W-1], esum_r} + {{(SUM_W-ERR_W+1){err[ERR_W-1]}}, err};
  assign delta     = {err[ERR_W-1], err} - {prev_err_r[ERR_W-1], prev_err_r};

  // saturating integral
  always_comb begin
    if (esum_wide[SUM_W] != esum_wide[SUM_W-1]) begin
      esum_nxt = esum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      esum_nxt = esum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      esum_r     <= '0;
      prev_err_r <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (accept) begin
        esum_r     <= esum_nxt;
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.err   <= err;
      s1_r.esum  <= esum_nxt;
      s1_r.delta <= delta;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_word  = s1_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted sample did not reach the error stage");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(esum_r) && $stable(prev_err_r)))
    else $error("controller state moved without a sample");

  a_stage_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_r.err == prev_err_r) && (s1_r.esum == esum_r))
    else $error("error stage out of step with stored state");

endmodule
`default_nettype wire

/* rtl/ypid_calc.sv */
`default_nettype none
module ypid_calc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ypid_pkg::gains_t          gains,
  input  logic                      s1_valid,
  input  ypid_pkg::err_word_t       s1_word,
  output logic                      s1_ready,
  output logic                      corr_valid,
  output logic signed [15:0]        corr,
  input  logic                      corr_ready
);
  import ypid_pkg::*;

  localparam int unsigned P_W   = DATA_W + ERR_W;
  localparam int unsigned I_W   = DATA_W + SUM_W;
  localparam int unsigned D_W   = DATA_W + ERR_W + 1;
  localparam int unsigned PID_W = I_W + 2;
  localparam int unsigned SH_W  = PID_W - FRAC_SHIFT;

  logic signed [P_W-1:0]   p_prod;
  logic signed [I_W-1:0]   i_prod;
  logic signed [D_W-1:0]   d_prod;
  logic signed [P_W-1:0]   p_r;
  logic signed [I_W-1:0]   i_r;
  logic signed [D_W-1:0]   d_r;
  logic                    s2_v_r;
  logic                    s2_v_nxt;
  logic                    s2_ready;
  logic                    s2_load;
  logic signed [PID_W-1:0] pid_sum;
  logic signed [SH_W-1:0]  shifted;
  logic signed [DATA_W-1:0] corr_nxt;
  logic signed [DATA_W-1:0] corr_r;
  logic                    s3_v_r;
  logic                    s3_v_nxt;
  logic                    s3_ready;
  logic                    s3_load;

  assign s3_ready = !s3_v_r || corr_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = s2_ready;
  assign s2_load  = s1_valid && s2_ready;
  assign s3_load  = s2_v_r && s3_ready;

  assign p_prod = P_W'(gains.p) * P_W'(s1_word.err);
  assign i_prod = I_W'(gains.i) * I_W'(s1_word.esum);
  assign d_prod = D_W'(gains.d) * D_W'(s1_word.delta);

  assign pid_sum = PID_W'(p_r) + PID_W'(i_r) + PID_W'(d_r);
  // arithmetic shift by dropping fraction bits rounds toward minus infinity
  assign shifted = pid_sum[PID_W-1:FRAC_SHIFT];

  always_comb begin
    if (shifted > SH_W'(S16_MAX)) begin
      corr_nxt = S16_MAX;
    end else if (shifted < SH_W'(S16_MIN)) begin
      corr_nxt = S16_MIN;
    end else begin
      corr_nxt = shifted[DATA_W-1:0];
    end
  end

  always_comb begin
    if (s2_load) begin
      s2_v_nxt = 1'b1;
    end else if (s3_ready) begin
      s2_v_nxt = 1'b0;
    end else begin
      s2_v_nxt = s2_v_r;
    end
    if (s3_load) begin
      s3_v_nxt = 1'b1;
    end else if (corr_ready) begin
      s3_v_nxt = 1'b0;
    end else begin
      s3_v_nxt = s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      p_r <= p_prod;
      i_r <= i_prod;
      d_r <= d_prod;
    end
    if (s3_load) begin
      corr_r <= corr_nxt;
    end
  end

  assign corr_valid = s3_v_r;
  assign corr       = corr_r;

endmodule
`default_nettype wire

/* rtl/ypid_mixer.sv */
`default_nettype none
module ypid_mixer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ypid_pkg::bases_t          bases,
  input  logic                      corr_valid,
  input  logic signed [15:0]        corr,
  output logic                      corr_ready,
  output logic                      out_valid,
  output logic [79:0]               out_data,
  input  logic                      out_ready
);
  import ypid_pkg::*;

  logic signed [DATA_W-1:0] drive_a;
  logic signed [DATA_W-1:0] drive_b;
  logic signed [DATA_W-1:0] drive_c;
  logic signed [DATA_W-1:0] drive_d;
  logic                     load;
  logic                     out_v_r;
  logic                     out_v_nxt;
  logic [79:0]              out_data_r;

  assign corr_ready = !out_v_r || out_ready;
  assign load       = corr_valid && corr_ready;

  assign drive_a = sat17({bases.a[DATA_W-1], bases.a} - {corr[DATA_W-1], corr});
  assign drive_b = sat17({bases.b[DATA_W-1], bases.b} - {corr[DATA_W-1], corr});
  assign drive_c = sat17({bases.c[DATA_W-1], bases.c} + {corr[DATA_W-1], corr});
  assign drive_d = sat17({bases.d[DATA_W-1], bases.d} + {corr[DATA_W-1], corr});

  always_comb begin
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {corr, drive_d, drive_c, drive_b, drive_a};
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
